>>> sv/c_escape_sequence_decoder_defines.svh
// ----------------------------------------------------------------------------
// C escape sequence decoder assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define C_ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define CESD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// checked on every edge, reset included
`define CESD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CESD_ASSERT(lbl, clk, rstn, prop, msg)
`define CESD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/cesd_pkg.sv
// ----------------------------------------------------------------------------
// C escape sequence decoder package
// Parse modes, queue entry and status types, character constants, helpers.
// ----------------------------------------------------------------------------
package cesd_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  // parse modes
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_OCT1  = 3'd4,
    MODE_OCT2  = 3'd5
  } mode_e;

  // character constants
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharX         = 8'h78;
  localparam logic [7:0] CharA         = 8'h61;
  localparam logic [7:0] CharB         = 8'h62;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharV         = 8'h76;

  // one queued decode: one or two result words
  typedef struct packed {
    logic       two;    // second word follows
    logic [8:0] ch0;
    logic       valid0;
    logic       end0;
    logic [7:0] ch1;    // raw terminator byte
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // simple escape code, zero when none
  function automatic logic [3:0] simple_escape(logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      CharA:   r = 4'd7;
      CharB:   r = 4'd8;
      CharF:   r = 4'd12;
      CharN:   r = 4'd10;
      CharR:   r = 4'd13;
      CharT:   r = 4'd9;
      CharV:   r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // nibble of a valid hex digit
  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) begin
      t = c - 8'h30;
    end else begin
      t = (c & 8'hDF) - 8'h37;
    end
    return t[3:0];
  endfunction

endpackage

>>> sv/cesd_front.sv
// ----------------------------------------------------------------------------
// C escape sequence decoder front end
// Accepts input words, runs the escape parser and pushes decoded entries.
// ----------------------------------------------------------------------------
module cesd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_char_i,
  input  logic               in_end_i,
  input  cesd_pkg::q_status_t q_status_i,
  output logic               push_o,
  output cesd_pkg::entry_t   entry_o
);

  cesd_pkg::mode_e mode_q, mode_d;
  logic [8:0]      dv_q, dv_d;
  logic            fire;
  logic [3:0]      esc;
  logic [8:0]      hex_nv;
  logic [8:0]      oct_nv;

  assign in_ready_o = !q_status_i.full;
  assign fire       = in_valid_i && in_ready_o;
  assign esc        = cesd_pkg::simple_escape(in_char_i);
  assign hex_nv     = {dv_q[4:0], cesd_pkg::hex_nibble(in_char_i)};
  assign oct_nv     = {dv_q[5:0], in_char_i[2:0]};

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cesd_pkg::MODE_PLAIN;
      dv_q   <= 9'd0;
    end else begin
      mode_q <= mode_d;
      dv_q   <= dv_d;
    end
  end

  // parser next state and pushed entry
  always_comb begin
    mode_d         = mode_q;
    dv_d           = dv_q;
    push_o         = 1'b0;
    entry_o.two    = 1'b0;
    entry_o.ch0    = {1'b0, in_char_i};
    entry_o.valid0 = 1'b1;
    entry_o.end0   = 1'b0;
    entry_o.ch1    = in_char_i;
    if (fire) begin
      if (in_end_i) begin
        push_o       = 1'b1;
        entry_o.end0 = 1'b1;
        if (mode_q == cesd_pkg::MODE_HEX0 || mode_q == cesd_pkg::MODE_HEX1 ||
            mode_q == cesd_pkg::MODE_OCT1 || mode_q == cesd_pkg::MODE_OCT2) begin
          entry_o.ch0 = dv_q;
        end else begin
          entry_o.ch0    = 9'd0;
          entry_o.valid0 = 1'b0;
        end
        mode_d = cesd_pkg::MODE_PLAIN;
        dv_d   = 9'd0;
      end else begin
        unique case (mode_q)
          cesd_pkg::MODE_ESC: begin
            if (esc != 4'd0) begin
              push_o      = 1'b1;
              entry_o.ch0 = {5'd0, esc};
              mode_d      = cesd_pkg::MODE_PLAIN;
            end else if (in_char_i == cesd_pkg::CharX) begin
              dv_d   = 9'd0;
              mode_d = cesd_pkg::MODE_HEX0;
            end else if (cesd_pkg::is_oct(in_char_i)) begin
              dv_d   = {6'd0, in_char_i[2:0]};
              mode_d = cesd_pkg::MODE_OCT1;
            end else begin
              push_o = 1'b1;
              mode_d = cesd_pkg::MODE_PLAIN;
            end
          end
          cesd_pkg::MODE_HEX0, cesd_pkg::MODE_HEX1: begin
            if (cesd_pkg::is_hex(in_char_i)) begin
              if (mode_q == cesd_pkg::MODE_HEX0) begin
                dv_d   = hex_nv;
                mode_d = cesd_pkg::MODE_HEX1;
              end else begin
                push_o      = 1'b1;
                entry_o.ch0 = hex_nv;
                mode_d      = cesd_pkg::MODE_PLAIN;
                dv_d        = 9'd0;
              end
            end else begin
              // value, then the raw terminator unless it is zero
              push_o      = 1'b1;
              entry_o.ch0 = dv_q;
              entry_o.two = (in_char_i != 8'd0);
              mode_d      = cesd_pkg::MODE_PLAIN;
              dv_d        = 9'd0;
            end
          end
          cesd_pkg::MODE_OCT1, cesd_pkg::MODE_OCT2: begin
            if (cesd_pkg::is_oct(in_char_i)) begin
              if (mode_q == cesd_pkg::MODE_OCT1) begin
                dv_d   = oct_nv;
                mode_d = cesd_pkg::MODE_OCT2;
              end else begin
                push_o      = 1'b1;
                entry_o.ch0 = oct_nv;
                mode_d      = cesd_pkg::MODE_PLAIN;
                dv_d        = 9'd0;
              end
            end else begin
              push_o      = 1'b1;
              entry_o.ch0 = dv_q;
              entry_o.two = (in_char_i != 8'd0);
              mode_d      = cesd_pkg::MODE_PLAIN;
              dv_d        = 9'd0;
            end
          end
          default: begin
            // plain text
            if (in_char_i == cesd_pkg::CharBackslash) begin
              mode_d = cesd_pkg::MODE_ESC;
            end else begin
              push_o = 1'b1;
              mode_d = cesd_pkg::MODE_PLAIN;
            end
            dv_d = 9'd0;
          end
        endcase
      end
    end
  end

endmodule

>>> sv/cesd_queue.sv
// ----------------------------------------------------------------------------
// C escape sequence decoder entry queue
// Small register FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module cesd_queue #(
  parameter int unsigned Depth = cesd_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cesd_pkg::entry_t    entry_i,
  input  logic                pop_i,
  output cesd_pkg::entry_t    head_o,
  output cesd_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cesd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/cesd_back.sv
// ----------------------------------------------------------------------------
// C escape sequence decoder back end
// Splits queued entries into output words and holds them in a register.
// ----------------------------------------------------------------------------
module cesd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cesd_pkg::entry_t    head_i,
  input  cesd_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [8:0]          out_char_o,
  output logic                out_char_valid_o,
  output logic                out_end_o
);

  logic       valid_q, valid_d;
  logic       phase_q, phase_d;
  logic [8:0] char_q;
  logic       cv_q, end_q;
  logic       load;

  assign load  = !q_status_i.empty && (!valid_q || out_ready_i);
  assign pop_o = load && (!head_i.two || phase_q);

  // phase and valid control
  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = head_i.two && !phase_q;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (phase_q) begin
        char_q <= {1'b0, head_i.ch1};
        cv_q   <= 1'b1;
        end_q  <= 1'b0;
      end else begin
        char_q <= head_i.ch0;
        cv_q   <= head_i.valid0;
        end_q  <= head_i.end0;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign out_char_o       = char_q;
  assign out_char_valid_o = cv_q;
  assign out_end_o        = end_q;

endmodule

>>> sv/c_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// C escape sequence decoder
// Decodes C string escapes from a byte stream ended by a tlast marker word.
//
//   channel  dir  tdata              tuser       tlast
//   s_axis   in   [7:0] char_in      -           end_in
//   m_axis   out  [8:0] char_out     char_valid  end_out
//
// One input word per cycle while the queue has room; each result word passes
// through the entry queue and the output register. A word that yields two
// results (escape value plus raw terminator) holds the output stage for a
// second word; the entry queue absorbs that, and input stalls only when full.
// Reset returns the parser to plain text and empties queue and output.
// ----------------------------------------------------------------------------
`include "c_escape_sequence_decoder_defines.svh"

module c_escape_sequence_decoder #(
  parameter int unsigned QueueDepth = cesd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  logic        s_axis_tlast_i,   // end_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [8:0] char_out, [15:9] zero
  output logic        m_axis_tuser_o,   // char_valid
  output logic        m_axis_tlast_o    // end_out
);

  cesd_pkg::entry_t    push_entry, head;
  cesd_pkg::q_status_t q_status;
  logic                push, pop;
  logic [8:0]          out_char;

  cesd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_char_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tlast_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  cesd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  cesd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_char_o       (out_char),
    .out_char_valid_o (m_axis_tuser_o),
    .out_end_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, out_char};

  // queue never written when full nor read when empty
  `CESD_ASSERT_ALWAYS(a_no_overflow, clk_i, push |-> !q_status.full, "queue overflow")
  `CESD_ASSERT_ALWAYS(a_no_underflow, clk_i, pop |-> !q_status.empty, "queue underflow")
  // an empty result only ever closes a string
  `CESD_ASSERT(a_empty_is_end, clk_i, rst_ni,
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tlast_o && out_char == 9'd0),
    "empty result without end marker")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// C escape sequence decoder testbench
// Streams byte strings with end markers into the decoder and checks every
// result word against a cycle-free prediction of the escape parser. A short
// directed string comes first, then random escape phrases. The sender works
// in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumWords = 1850;

  // digit bounds not covered by the package constants
  localparam logic [7:0] Digit0 = 8'h30;
  localparam logic [7:0] Digit7 = 8'h37;
  localparam logic [7:0] Digit9 = 8'h39;
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperF = 8'h46;

  typedef struct {
    logic [8:0] code;
    logic       valid;
    logic       last;
  } char_result_t;

  // receiver stall patterns
  typedef enum int {RX_FREE, RX_COIN, RX_SKIP3, RX_SLOW} rx_style_e;

  // Tracks the parser state and holds the decoded words still to come.
  class char_tracker;
    cesd_pkg::mode_e mode;
    logic [8:0]      digits;
    char_result_t    pending[$];
    int              errors;

    function new();
      mode   = cesd_pkg::MODE_PLAIN;
      digits = '0;
      errors = 0;
    endfunction

    function void expect_char(logic [8:0] code, logic valid, logic last);
      char_result_t r;
      r.code  = code;
      r.valid = valid;
      r.last  = last;
      pending.push_back(r);
    endfunction

    // a non-digit ends a numeric escape: value, then the raw byte unless zero
    function void close_value(logic [7:0] c);
      expect_char(digits, 1'b1, 1'b0);
      if (c != 8'h00) expect_char({1'b0, c}, 1'b1, 1'b0);
      mode   = cesd_pkg::MODE_PLAIN;
      digits = '0;
    endfunction

    // predict the words caused by one accepted input word
    function void note_word(logic [7:0] c, logic last);
      logic [3:0] nib;
      logic       is_hex;
      if (last) begin
        if (mode == cesd_pkg::MODE_HEX0 || mode == cesd_pkg::MODE_HEX1 ||
            mode == cesd_pkg::MODE_OCT1 || mode == cesd_pkg::MODE_OCT2) begin
          expect_char(digits, 1'b1, 1'b1);
        end else begin
          expect_char(9'd0, 1'b0, 1'b1);
        end
        mode   = cesd_pkg::MODE_PLAIN;
        digits = '0;
        return;
      end
      is_hex = 1'b1;
      nib    = '0;
      if (c >= Digit0 && c <= Digit9) begin
        nib = 4'(c - Digit0);
      end else if (c >= UpperA && c <= UpperF) begin
        nib = 4'(c - UpperA + 8'd10);
      end else if (c >= cesd_pkg::CharA && c <= cesd_pkg::CharF) begin
        nib = 4'(c - cesd_pkg::CharA + 8'd10);
      end else begin
        is_hex = 1'b0;
      end
      case (mode)
        cesd_pkg::MODE_ESC: begin
          mode = cesd_pkg::MODE_PLAIN;
          case (c)
            cesd_pkg::CharA: expect_char(9'd7, 1'b1, 1'b0);
            cesd_pkg::CharB: expect_char(9'd8, 1'b1, 1'b0);
            cesd_pkg::CharF: expect_char(9'd12, 1'b1, 1'b0);
            cesd_pkg::CharN: expect_char(9'd10, 1'b1, 1'b0);
            cesd_pkg::CharR: expect_char(9'd13, 1'b1, 1'b0);
            cesd_pkg::CharT: expect_char(9'd9, 1'b1, 1'b0);
            cesd_pkg::CharV: expect_char(9'd11, 1'b1, 1'b0);
            cesd_pkg::CharX: begin
              digits = '0;
              mode   = cesd_pkg::MODE_HEX0;
            end
            default: begin
              if (c >= Digit0 && c <= Digit7) begin
                digits = {6'd0, c[2:0]};
                mode   = cesd_pkg::MODE_OCT1;
              end else begin
                expect_char({1'b0, c}, 1'b1, 1'b0);
              end
            end
          endcase
        end
        cesd_pkg::MODE_HEX0, cesd_pkg::MODE_HEX1: begin
          if (is_hex) begin
            digits = {digits[4:0], nib};
            if (mode == cesd_pkg::MODE_HEX0) begin
              mode = cesd_pkg::MODE_HEX1;
            end else begin
              expect_char(digits, 1'b1, 1'b0);
              mode   = cesd_pkg::MODE_PLAIN;
              digits = '0;
            end
          end else begin
            close_value(c);
          end
        end
        cesd_pkg::MODE_OCT1, cesd_pkg::MODE_OCT2: begin
          if (c >= Digit0 && c <= Digit7) begin
            digits = {digits[5:0], c[2:0]};
            if (mode == cesd_pkg::MODE_OCT1) begin
              mode = cesd_pkg::MODE_OCT2;
            end else begin
              expect_char(digits, 1'b1, 1'b0);
              mode   = cesd_pkg::MODE_PLAIN;
              digits = '0;
            end
          end else begin
            close_value(c);
          end
        end
        default: begin
          if (c == cesd_pkg::CharBackslash) begin
            mode = cesd_pkg::MODE_ESC;
          end else begin
            expect_char({1'b0, c}, 1'b1, 1'b0);
          end
          digits = '0;
        end
      endcase
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(logic [8:0] code, logic valid, logic last);
      char_result_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: char_out %0d", code);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (code !== want.code) begin
        $error("char_out: expected %0d, got %0d", want.code, code);
        errors++;
      end
      if (valid !== want.valid) begin
        $error("char_valid: expected %0b, got %0b", want.valid, valid);
        errors++;
      end
      if (last !== want.last) begin
        $error("end_out: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] char_in
  logic        s_axis_tlast_i;   // end_in
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;   // [8:0] char_out, [15:9] zero
  logic        m_axis_tuser_o;   // char_valid
  logic        m_axis_tlast_o;   // end_out

  char_tracker sb = new();
  int          words_sent = 0;
  int          burst_left = 0;
  int          rx_cycle   = 0;
  rx_style_e   rx_style   = RX_FREE;

  c_escape_sequence_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // receiver: drives ready from a randomly chosen stall style
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
    case (rx_style)
      RX_FREE:  m_axis_tready_i <= 1'b1;
      RX_COIN:  m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_SKIP3: m_axis_tready_i <= (rx_cycle % 3) != 0;
      default:  m_axis_tready_i <= (rx_cycle % 16) < 3;
    endcase
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_word(m_axis_tdata_o[8:0], m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // send one word, opening a new burst after a random gap when due
  task automatic send_word(logic [7:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(c, last);
    words_sent++;
  endtask

  // hold off until every predicted word has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_hex_digit();
    string hex_chars;
    hex_chars = "0123456789abcdefABCDEF";
    send_word(hex_chars[$urandom_range(0, 21)], 1'b0);
  endtask

  // what follows a short numeric escape
  task automatic send_close();
    case ($urandom_range(0, 4))
      0: send_word(8'h00, 1'b0);
      1: send_word(8'($urandom_range(0, 255)), 1'b0);
      2: send_word(8'($urandom_range(0, 255)), 1'b1);
      3: ;
      default: send_hex_digit();
    endcase
  endtask

  // one random phrase: mostly well-formed escapes, some noise
  task automatic send_phrase();
    int kind;
    int ndig;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 40) begin
      send_word(cesd_pkg::CharBackslash, 1'b0);
      case ($urandom_range(0, 6))
        0: send_word(cesd_pkg::CharA, 1'b0);
        1: send_word(cesd_pkg::CharB, 1'b0);
        2: send_word(cesd_pkg::CharF, 1'b0);
        3: send_word(cesd_pkg::CharN, 1'b0);
        4: send_word(cesd_pkg::CharR, 1'b0);
        5: send_word(cesd_pkg::CharT, 1'b0);
        default: send_word(cesd_pkg::CharV, 1'b0);
      endcase
    end else if (kind < 55) begin
      send_word(cesd_pkg::CharBackslash, 1'b0);
      send_word(cesd_pkg::CharX, 1'b0);
      ndig = $urandom_range(0, 2);
      repeat (ndig) send_hex_digit();
      if (ndig < 2) send_close();
    end else if (kind < 70) begin
      send_word(cesd_pkg::CharBackslash, 1'b0);
      ndig = $urandom_range(1, 3);
      repeat (ndig) send_word(Digit0 + 8'($urandom_range(0, 7)), 1'b0);
      if (ndig < 3) send_close();
    end else if (kind < 78) begin
      send_word(cesd_pkg::CharBackslash, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 88) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    bit paused;
    paused          = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed string
    send_word(8'h00, 1'b0);                      // zero byte passes through
    send_word(8'hFF, 1'b0);
    send_word(cesd_pkg::CharBackslash, 1'b0);
    send_word(cesd_pkg::CharN, 1'b0);
    send_word(cesd_pkg::CharBackslash, 1'b0);    // two hex digits, largest
    send_word(cesd_pkg::CharX, 1'b0);
    send_word(UpperF, 1'b0);
    send_word(cesd_pkg::CharF, 1'b0);
    send_word(cesd_pkg::CharBackslash, 1'b0);    // octal 777 gives 511
    send_word(Digit7, 1'b0);
    send_word(Digit7, 1'b0);
    send_word(Digit7, 1'b0);
    send_word(cesd_pkg::CharBackslash, 1'b0);    // octal ended by a zero byte
    send_word("1", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(cesd_pkg::CharBackslash, 1'b0);    // hex with no digit, raw terminator
    send_word(cesd_pkg::CharX, 1'b0);
    send_word("z", 1'b0);
    send_word(cesd_pkg::CharBackslash, 1'b0);    // lone backslash at end is dropped
    send_word(8'hA5, 1'b1);
    send_word(cesd_pkg::CharBackslash, 1'b0);    // hex with no digit flushed at end
    send_word(cesd_pkg::CharX, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b1);                      // end in plain text
    send_word(cesd_pkg::CharBackslash, 1'b0);    // unknown escape is literal
    send_word("q", 1'b0);
    wait_drained();

    // random phrases, with one full drain halfway
    while (words_sent < NumWords) begin
      send_phrase();
      if (!paused && words_sent >= NumWords / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS c_escape_sequence_decoder");
    end else begin
      $display("FAIL c_escape_sequence_decoder");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAIL c_escape_sequence_decoder");
    $finish;
  end

endmodule
